FILE: src/ptt_pkg.sv
// Shared constants and types for the packet timing tracker.
`default_nettype none

package ptt_pkg;

    // Field widths
    localparam int TIME_W  = 64;
    localparam int STAMP_W = 32;
    localparam int FRAME_W = 32;
    localparam int DELAY_W = 48;
    localparam int COUNT_W = 32;

    // Stamp bits in use and fraction bits of the fixed-point averages
    localparam int STAMP_BITS = 32;
    localparam int FRAC_BITS  = 16;

    // Delay is held to a signed integer of this many magnitude bits before scaling
    localparam int DELAY_LIM_BITS = DELAY_W - 1 - FRAC_BITS;

    // Loss divider: dividend is the newest stamp in fixed point
    localparam int DIV_N_W   = STAMP_W + FRAC_BITS;
    localparam int DIV_D_W   = 32;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    // Average numerators: frame is unsigned, delay is signed with growth for 49x plus sample
    localparam int FNUM_W = FRAME_W + 7;
    localparam int DNUM_W = DELAY_W + 7;

    // Divide by 50: radix 2^16 digits, each digit found by reciprocal multiplication.
    // Reciprocal is ceil(2^27 / 50); exact for every remainder-and-digit value.
    localparam int D50_DIG_W  = 16;
    localparam int D50_DIGITS = 4;
    localparam int D50_N_W    = D50_DIG_W * D50_DIGITS;
    localparam int D50_CNT_W  = $clog2(D50_DIGITS + 1);
    localparam int D50_REM_W  = 6;
    localparam int D50_V_W    = D50_REM_W + D50_DIG_W;
    localparam int D50_PROD_W = 2 * D50_V_W;
    localparam int D50_SHIFT  = 27;
    localparam logic [D50_V_W-1:0] D50_RECIP = D50_V_W'(2684355);

    // Input queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [STAMP_W-1:0] STAMP_MASK = STAMP_W'((64'd1 << STAMP_BITS) - 64'd1);
    localparam logic [FRAME_W-1:0] INTERVAL_RESET = FRAME_W'(64'd100 << FRAC_BITS);

    // Running average weights: new = (49 * old + sample + 25) / 50
    localparam int AVG_KEEP  = 49;
    localparam int AVG_DIV   = 50;
    localparam int AVG_ROUND = 25;

    // One packet as classified by the front end
    typedef struct packed {
        logic [TIME_W-1:0]  recv;
        logic [STAMP_W-1:0] stamp;
        logic [TIME_W-1:0]  off;
    } ptt_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASS,
        ST_DELAY,
        ST_NUM,
        ST_SIGN,
        ST_AVG,
        ST_LOST,
        ST_OUT
    } ptt_state_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } ptt_div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } ptt_div_rsp_t;

    typedef struct packed {
        logic               start;
        logic [D50_N_W-1:0] dividend;
    } ptt_d50_req_t;

    typedef struct packed {
        logic               done;
        logic [D50_N_W-1:0] quotient;
    } ptt_d50_rsp_t;

endpackage

`default_nettype wire

FILE: src/ptt_div.sv
// Dividers: restoring serial divider for the loss estimate and a digit-serial divide by 50.
`default_nettype none

module ptt_div (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ptt_pkg::ptt_div_req_t req,
    output ptt_pkg::ptt_div_rsp_t      rsp
);
    import ptt_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W-1:0]   dsr_reg, dsr_next;

    logic [DIV_D_W:0] trial;
    logic [DIV_D_W:0] trial_diff;
    logic             fits;

    // Trial subtract of the divisor from the shifted remainder
    assign trial      = {rem_reg, quo_reg[DIV_N_W-1]};
    assign trial_diff = trial - {1'b0, dsr_reg};
    assign fits       = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_N_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial_diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            quo_next = {quo_reg[DIV_N_W-2:0], fits};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// Divide by 50, one 16-bit quotient digit per cycle, most significant digit first
module ptt_div50 (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ptt_pkg::ptt_d50_req_t req,
    output ptt_pkg::ptt_d50_rsp_t      rsp
);
    import ptt_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [D50_CNT_W-1:0] cnt_reg, cnt_next;
    logic [D50_REM_W-1:0] rem_reg, rem_next;
    logic [D50_N_W-1:0]   num_reg, num_next;

    logic [D50_V_W-1:0]    part;
    logic [D50_PROD_W-1:0] prod;
    logic [D50_DIG_W-1:0]  qdig;
    logic [D50_V_W-1:0]    back;
    logic [D50_V_W-1:0]    part_rem;

    // Remainder joined with the next digit, times the reciprocal of 50
    assign part     = {rem_reg, num_reg[D50_N_W-1 -: D50_DIG_W]};
    assign prod     = D50_PROD_W'(part) * D50_PROD_W'(D50_RECIP);
    assign qdig     = prod[D50_SHIFT +: D50_DIG_W];
    assign back     = D50_V_W'(qdig) * D50_V_W'(AVG_DIV);
    assign part_rem = part - back;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = D50_CNT_W'(D50_DIGITS);
            rem_next  = '0;
            num_next  = req.dividend;
        end
        else if (busy_reg)
        begin
            rem_next = part_rem[D50_REM_W-1:0];
            num_next = {num_reg[D50_N_W-D50_DIG_W-1:0], qdig};
            cnt_next = cnt_reg - D50_CNT_W'(1);
            if (cnt_reg == D50_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = num_reg;

endmodule

`default_nettype wire

FILE: src/ptt_front.sv
// Front end: takes packet requests, forms the start offset, queues them for the back end.
`default_nettype none

module ptt_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [63:0]            receive_time,
    input  wire logic [31:0]            sensor_stamp,
    output ptt_pkg::ptt_item_t          item,
    output logic                        item_valid,
    input  wire logic                   item_pop
);
    import ptt_pkg::*;

    ptt_item_t         q_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    ptt_item_t   new_item;
    logic        wr_en;
    logic        rd_en;
    logic [STAMP_W-1:0] stamp_m;

    // Classify: mask the stamp and form receive minus stamp
    assign stamp_m       = sensor_stamp & STAMP_MASK;
    assign new_item.recv  = receive_time;
    assign new_item.stamp = stamp_m;
    assign new_item.off   = receive_time - TIME_W'(stamp_m);

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign item_valid = (cnt_reg != '0);
    assign wr_en      = push && !full;
    assign rd_en      = item_pop && item_valid;
    assign item       = q_mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_mem[wr_ptr_reg] <= new_item;
        end
    end

endmodule

`default_nettype wire

FILE: src/ptt_core.sv
// Back end: updates timing statistics, runs the averages and loss estimate, holds the result.
`default_nettype none

module ptt_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_data,
    input  wire ptt_pkg::ptt_item_t item,
    input  wire logic               item_valid,
    output logic                    item_pop,
    output logic                    empty,
    input  wire logic               pop,
    output logic [31:0]             avg_frame_time,
    output logic signed [47:0]      avg_delay,
    output logic [31:0]             packets_received,
    output logic [31:0]             packets_lost,
    output logic                    restarted,
    output logic [63:0]             start_offset
);
    import ptt_pkg::*;

    // Control and statistics state
    ptt_state_t         state_reg, state_next;
    logic               sync_reg, sync_next;
    logic [TIME_W-1:0]  start_time_reg, start_time_next;
    logic               start_valid_reg, start_valid_next;
    logic [STAMP_W-1:0] newest_reg, newest_next;
    logic [FRAME_W-1:0] li_reg, li_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               out_valid_reg, out_valid_next;

    // Working registers for the item in flight
    logic [TIME_W-1:0]  recv_reg, recv_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic [TIME_W-1:0]  off_reg, off_next;
    logic               restart_reg, restart_next;
    logic [DELAY_W-1:0] cur_delay_reg, cur_delay_next;
    logic [FNUM_W-1:0]  fnum_reg, fnum_next;
    logic [DNUM_W-1:0]  dnum_reg, dnum_next;
    logic               dneg_reg, dneg_next;
    logic               fzero_reg, fzero_next;
    logic [COUNT_W-1:0] lost_reg, lost_next;

    // Result registers
    logic [FRAME_W-1:0] o_frame_reg, o_frame_next;
    logic [DELAY_W-1:0] o_delay_reg, o_delay_next;
    logic [COUNT_W-1:0] o_count_reg, o_count_next;
    logic [COUNT_W-1:0] o_lost_reg, o_lost_next;
    logic               o_restart_reg, o_restart_next;
    logic [TIME_W-1:0]  o_start_reg, o_start_next;

    // Dividers: two divide-by-50 units for the averages, one serial divider for the loss
    ptt_d50_req_t fdiv_req, ddiv_req;
    ptt_d50_rsp_t fdiv_rsp, ddiv_rsp;
    ptt_div_req_t ldiv_req;
    ptt_div_rsp_t ldiv_rsp;
    logic         avg_done;

    // Combinational helpers
    logic                          fwd;
    logic [STAMP_W-1:0]            stamp_diff;
    logic [FRAME_W-1:0]            iv;
    logic                          restart_c;
    logic                          sync_hit;
    logic [TIME_W-1:0]             raw;
    logic [TIME_W-1:DELAY_LIM_BITS] raw_hi;
    logic [DELAY_LIM_BITS:0]       cur_int;
    logic [DELAY_W-1:0]            cur_delay;
    logic [FRAME_W-1:0]            f0;
    logic [FNUM_W-1:0]             fnum;
    logic [DNUM_W-1:0]             delay_ext;
    logic [DNUM_W-1:0]             cur_ext;
    logic [DNUM_W-1:0]             dnum;
    logic [DNUM_W-1:0]             dmag;
    logic [DNUM_W-1:0]             dmag_adj;
    logic [FRAME_W-1:0]            fq;
    logic [DELAY_W-1:0]            dq;
    logic [DELAY_W-1:0]            delay_new;
    logic [DIV_N_W-1:0]            lost_dividend;
    logic [DIV_N_W-1:0]            cnt_ext;
    logic [DIV_N_W-1:0]            ldiff;
    logic [COUNT_W-1:0]            lost;

    ptt_div50 u_fdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fdiv_req),
        .rsp   (fdiv_rsp)
    );

    ptt_div50 u_ddiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ddiv_req),
        .rsp   (ddiv_rsp)
    );

    ptt_div u_ldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ldiv_req),
        .rsp   (ldiv_rsp)
    );

    // Classification: forward stamp, saturated interval, restart detect, new minimum offset
    assign fwd        = (stamp_reg > newest_reg);
    assign stamp_diff = stamp_reg - newest_reg;
    assign iv         = ((FRAME_W'(stamp_diff) >> (FRAME_W - FRAC_BITS)) != '0) ? '1
                        : (FRAME_W'(stamp_diff) << FRAC_BITS);
    assign restart_c  = ({stamp_reg, 1'b0} < {1'b0, newest_reg});
    assign sync_hit   = sync_reg && (!start_valid_reg || (off_reg < start_time_reg));

    // Current delay, held to the integer range and scaled to fixed point
    assign raw    = recv_reg - start_time_reg - TIME_W'(newest_reg);
    assign raw_hi = raw[TIME_W-1:DELAY_LIM_BITS];
    always_comb
    begin
        if ((raw_hi == '0) || (raw_hi == '1))
        begin
            cur_int = raw[DELAY_LIM_BITS:0];
        end
        else if (raw[TIME_W-1])
        begin
            cur_int = {1'b1, {DELAY_LIM_BITS{1'b0}}};
        end
        else
        begin
            cur_int = {1'b0, {DELAY_LIM_BITS{1'b1}}};
        end
    end
    assign cur_delay = {cur_int, {FRAC_BITS{1'b0}}};

    // Average numerators
    assign f0   = (frame_reg == '0) ? li_reg : frame_reg;
    assign fnum = FNUM_W'(f0) * FNUM_W'(AVG_KEEP) + FNUM_W'(li_reg) + FNUM_W'(AVG_ROUND);

    assign delay_ext = {{(DNUM_W - DELAY_W){delay_reg[DELAY_W-1]}}, delay_reg};
    assign cur_ext   = {{(DNUM_W - DELAY_W){cur_delay_reg[DELAY_W-1]}}, cur_delay_reg};
    assign dnum      = delay_ext * DNUM_W'(AVG_KEEP) + cur_ext + DNUM_W'(AVG_ROUND);

    // Floor division of a negative numerator: negate, bias by divisor minus one
    assign dmag     = dnum_reg[DNUM_W-1] ? (~dnum_reg + DNUM_W'(1)) : dnum_reg;
    assign dmag_adj = dnum_reg[DNUM_W-1] ? (dmag + DNUM_W'(AVG_DIV - 1)) : dmag;

    // Quotients
    assign avg_done  = fdiv_rsp.done && ddiv_rsp.done;
    assign fq        = fdiv_rsp.quotient[FRAME_W-1:0];
    assign dq        = ddiv_rsp.quotient[DELAY_W-1:0];
    assign delay_new = dneg_reg ? (~dq + DELAY_W'(1)) : dq;

    // Loss estimate from the stamp count quotient
    assign lost_dividend = DIV_N_W'({newest_reg, {FRAC_BITS{1'b0}}});
    assign cnt_ext       = DIV_N_W'(count_reg);
    assign ldiff         = ldiv_rsp.quotient - cnt_ext;
    always_comb
    begin
        if (fzero_reg || (ldiv_rsp.quotient <= cnt_ext))
        begin
            lost = '0;
        end
        else if ((ldiff >> COUNT_W) != '0)
        begin
            lost = '1;
        end
        else
        begin
            lost = ldiff[COUNT_W-1:0];
        end
    end

    // Divider requests
    always_comb
    begin
        fdiv_req.start    = (state_reg == ST_SIGN);
        fdiv_req.dividend = D50_N_W'(fnum_reg);
        ddiv_req.start    = (state_reg == ST_SIGN);
        ddiv_req.dividend = D50_N_W'(dmag_adj);
        ldiv_req.start    = (state_reg == ST_AVG) && avg_done;
        ldiv_req.dividend = lost_dividend;
        ldiv_req.divisor  = DIV_D_W'(fq);
    end

    assign cfg_ready = 1'b1;

    // Sequencer: next state and register updates
    always_comb
    begin
        state_next       = state_reg;
        sync_next        = (cfg_valid && cfg_ready) ? cfg_data : sync_reg;
        start_time_next  = start_time_reg;
        start_valid_next = start_valid_reg;
        newest_next      = newest_reg;
        li_next          = li_reg;
        frame_next       = frame_reg;
        delay_next       = delay_reg;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg && !pop;
        recv_next        = recv_reg;
        stamp_next       = stamp_reg;
        off_next         = off_reg;
        restart_next     = restart_reg;
        cur_delay_next   = cur_delay_reg;
        fnum_next        = fnum_reg;
        dnum_next        = dnum_reg;
        dneg_next        = dneg_reg;
        fzero_next       = fzero_reg;
        lost_next        = lost_reg;
        o_frame_next     = o_frame_reg;
        o_delay_next     = o_delay_reg;
        o_count_next     = o_count_reg;
        o_lost_next      = o_lost_reg;
        o_restart_next   = o_restart_reg;
        o_start_next     = o_start_reg;
        item_pop         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop   = 1'b1;
                    recv_next  = item.recv;
                    stamp_next = item.stamp;
                    off_next   = item.off;
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS:
            begin
                if (sync_hit)
                begin
                    start_time_next  = off_reg;
                    start_valid_next = 1'b1;
                end
                if (fwd)
                begin
                    li_next     = iv;
                    newest_next = stamp_reg;
                end
                if (count_reg != '1)
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
                restart_next = restart_c;
                if (restart_c)
                begin
                    start_time_next  = off_reg;
                    start_valid_next = 1'b1;
                    count_next       = '0;
                    newest_next      = '0;
                    frame_next       = '0;
                    li_next          = INTERVAL_RESET;
                    delay_next       = '0;
                end
                state_next = ST_DELAY;
            end
            ST_DELAY:
            begin
                cur_delay_next = restart_reg ? '0 : cur_delay;
                fnum_next      = fnum;
                state_next     = ST_NUM;
            end
            ST_NUM:
            begin
                dnum_next  = dnum;
                state_next = ST_SIGN;
            end
            ST_SIGN:
            begin
                dneg_next  = dnum_reg[DNUM_W-1];
                state_next = ST_AVG;
            end
            ST_AVG:
            begin
                if (avg_done)
                begin
                    frame_next = fq;
                    delay_next = delay_new;
                    fzero_next = (fq == '0);
                    state_next = ST_LOST;
                end
            end
            ST_LOST:
            begin
                if (ldiv_rsp.done)
                begin
                    lost_next  = lost;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    o_frame_next   = frame_reg;
                    o_delay_next   = delay_reg;
                    o_count_next   = count_reg;
                    o_lost_next    = lost_reg;
                    o_restart_next = restart_reg;
                    o_start_next   = start_time_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and statistics state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            sync_reg        <= 1'b1;
            start_time_reg  <= '0;
            start_valid_reg <= 1'b0;
            newest_reg      <= '0;
            li_reg          <= INTERVAL_RESET;
            frame_reg       <= '0;
            delay_reg       <= '0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            sync_reg        <= sync_next;
            start_time_reg  <= start_time_next;
            start_valid_reg <= start_valid_next;
            newest_reg      <= newest_next;
            li_reg          <= li_next;
            frame_reg       <= frame_next;
            delay_reg       <= delay_next;
            count_reg       <= count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        recv_reg      <= recv_next;
        stamp_reg     <= stamp_next;
        off_reg       <= off_next;
        restart_reg   <= restart_next;
        cur_delay_reg <= cur_delay_next;
        fnum_reg      <= fnum_next;
        dnum_reg      <= dnum_next;
        dneg_reg      <= dneg_next;
        fzero_reg     <= fzero_next;
        lost_reg      <= lost_next;
        o_frame_reg   <= o_frame_next;
        o_delay_reg   <= o_delay_next;
        o_count_reg   <= o_count_next;
        o_lost_reg    <= o_lost_next;
        o_restart_reg <= o_restart_next;
        o_start_reg   <= o_start_next;
    end

    assign empty            = !out_valid_reg;
    assign avg_frame_time   = o_frame_reg;
    assign avg_delay        = o_delay_reg;
    assign packets_received = o_count_reg;
    assign packets_lost     = o_lost_reg;
    assign restarted        = o_restart_reg;
    assign start_offset     = o_start_reg;

endmodule

`default_nettype wire

FILE: src/packet_timing_tracker.sv
// Packet timing tracker top level: input queue front end and statistics back end.
// The back end works on one request at a time, its processing set mostly by the 48-step
// serial division of the loss estimate; before it both averages divide by 50 in four
// digit steps.
// A two-entry input queue and the result register let both sides stall independently.
// Reset (rst_n low, asynchronous) clears the statistics and queues; synchronizing resets to 1.
`default_nettype none

module packet_timing_tracker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [63:0]   receive_time,
    input  wire logic [31:0]   sensor_stamp,
    output logic               empty,
    input  wire logic          pop,
    output logic [31:0]        avg_frame_time,
    output logic signed [47:0] avg_delay,
    output logic [31:0]        packets_received,
    output logic [31:0]        packets_lost,
    output logic               restarted,
    output logic [63:0]        start_offset,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic          cfg_data
);
    import ptt_pkg::*;

    ptt_item_t item;
    logic      item_valid;
    logic      item_pop;

    ptt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .receive_time (receive_time),
        .sensor_stamp (sensor_stamp),
        .item         (item),
        .item_valid   (item_valid),
        .item_pop     (item_pop)
    );

    ptt_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .item             (item),
        .item_valid       (item_valid),
        .item_pop         (item_pop),
        .empty            (empty),
        .pop              (pop),
        .avg_frame_time   (avg_frame_time),
        .avg_delay        (avg_delay),
        .packets_received (packets_received),
        .packets_lost     (packets_lost),
        .restarted        (restarted),
        .start_offset     (start_offset)
    );

endmodule

`default_nettype wire

FILE: src/ptt_checker.sv
// Port-level checks for the packet timing tracker, bound to the top level.
`default_nettype none

module ptt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [31:0] avg_frame_time,
    input wire logic [47:0] avg_delay,
    input wire logic [31:0] packets_received,
    input wire logic        restarted,
    input wire logic [63:0] start_offset
);

    // Queues come up empty while reset is held
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> (empty && !full))
        else $error("queues not empty during reset");

    // A waiting result holds until it is popped
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(avg_frame_time) && $stable(start_offset)))
        else $error("waiting result changed before pop");

    // A restart clears the packet count and the delay average
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && restarted) |-> (packets_received == 32'd0 && avg_delay == 48'd0))
        else $error("restart did not clear statistics");

    // Frame average is loaded from a nonzero interval on every packet
    a_frame_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (avg_frame_time != 32'd0))
        else $error("frame average is zero on a result");

endmodule

bind packet_timing_tracker ptt_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .full             (full),
    .empty            (empty),
    .pop              (pop),
    .avg_frame_time   (avg_frame_time),
    .avg_delay        (avg_delay),
    .packets_received (packets_received),
    .restarted        (restarted),
    .start_offset     (start_offset)
);

`default_nettype wire
